FILE: rtl/core/sha1_pkg.sv
// Shared types, constants and round functions of the SHA-1 stream hasher.
`default_nettype none

package sha1_pkg;

    typedef logic [31:0] word_t;
    typedef logic [4:0][31:0] chain_t;
    typedef logic [6:0] rnd_idx_t;

    // Initial chaining value, word 0 in the lowest slot
    localparam chain_t CHAIN_IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                   32'hEFCDAB89, 32'h67452301};

    localparam word_t K_CH  = 32'h5A827999;
    localparam word_t K_PAR = 32'h6ED9EBA1;
    localparam word_t K_MAJ = 32'h8F1BBCDC;
    localparam word_t K_XOR = 32'hCA62C1D6;

    localparam rnd_idx_t RND_GROUP1 = 7'd20;
    localparam rnd_idx_t RND_GROUP2 = 7'd40;
    localparam rnd_idx_t RND_GROUP3 = 7'd60;
    localparam rnd_idx_t RND_LAST   = 7'd79;

    localparam logic       CMD_ABSORB = 1'b0;
    localparam logic       CMD_FINISH = 1'b1;
    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [2:0] WORD_LAST  = 3'd4;

    // Control from the sequencer to the message window
    typedef struct packed {
        logic       push_byte;
        logic [7:0] byte_val;
        logic       step;
    } sched_ctrl_t;

    // Control from the sequencer to the round unit
    typedef struct packed {
        logic     load;
        logic     step;
        logic     fold;
        logic     init;
        rnd_idx_t rnd;
    } rnd_ctrl_t;

    function automatic word_t round_f(rnd_idx_t rnd, word_t b, word_t c, word_t d);
        word_t f;
        if (rnd < RND_GROUP1) begin
            f = (b & c) | (~b & d);
        end else if (rnd < RND_GROUP2) begin
            f = b ^ c ^ d;
        end else if (rnd < RND_GROUP3) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    function automatic word_t round_k(rnd_idx_t rnd);
        word_t k;
        if (rnd < RND_GROUP1) begin
            k = K_CH;
        end else if (rnd < RND_GROUP2) begin
            k = K_PAR;
        end else if (rnd < RND_GROUP3) begin
            k = K_MAJ;
        end else begin
            k = K_XOR;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sha1_sched.sv
// Message window: byte packing and the rolling 16-word message schedule.
`default_nettype none

module sha1_sched
    import sha1_pkg::*;
(
    input  wire         aclk,
    input  sched_ctrl_t ctrl,
    output word_t       w_cur
);

    logic [511:0] win_reg;
    word_t        w_new;

    // Oldest word sits at the top; taps are words 0, 2, 8 and 13 of the window
    assign w_cur = win_reg[511:480];

    always_comb begin
        w_new = win_reg[511:480] ^ win_reg[447:416] ^ win_reg[255:224] ^ win_reg[95:64];
        w_new = {w_new[30:0], w_new[31]};
    end

    // Shift in a byte while filling, a schedule word while running rounds
    always_ff @(posedge aclk) begin
        if (ctrl.push_byte) begin
            win_reg <= {win_reg[503:0], ctrl.byte_val};
        end else if (ctrl.step) begin
            win_reg <= {win_reg[479:0], w_new};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sha1_round.sv
// Shared round unit: working variables, one SHA-1 round per cycle, chaining words.
`default_nettype none

module sha1_round
    import sha1_pkg::*;
(
    input  wire       aclk,
    input  wire       aresetn,
    input  rnd_ctrl_t ctrl,
    input  word_t     w_cur,
    output chain_t    chain
);

    word_t  a_reg, b_reg, c_reg, d_reg, e_reg;
    chain_t chain_reg;
    word_t  t_sum;

    assign chain = chain_reg;

    // One round: rotl(a,5) + f + e + k + w
    always_comb begin
        t_sum = {a_reg[26:0], a_reg[31:27]} + round_f(ctrl.rnd, b_reg, c_reg, d_reg)
              + e_reg + round_k(ctrl.rnd) + w_cur;
    end

    // Load from the chain, then advance one round per step
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end else if (ctrl.step) begin
            e_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            b_reg <= a_reg;
            a_reg <= t_sum;
        end
    end

    // Fold the working variables into the chain, or restart it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg <= CHAIN_IV;
        end else if (ctrl.init) begin
            chain_reg <= CHAIN_IV;
        end else if (ctrl.fold) begin
            chain_reg[0] <= chain_reg[0] + a_reg;
            chain_reg[1] <= chain_reg[1] + b_reg;
            chain_reg[2] <= chain_reg[2] + c_reg;
            chain_reg[3] <= chain_reg[3] + d_reg;
            chain_reg[4] <= chain_reg[4] + e_reg;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sha1_stream_hasher_top.sv
// Top level of the SHA-1 stream hasher: sequencer, padding and digest output.
`default_nettype none

// Takes one message byte per word on the slave side (s_tuser = 0); the 64th byte
// of a block starts the compression, which runs 80 rounds through a single shared
// round unit, one round per cycle, then folds the result into the chaining words. A
// finish word (s_tuser = 1) pads the message one byte per cycle and compresses one
// or two final blocks (two when more than 55 bytes were buffered), then emits the
// digest as five 32-bit words, most significant first, m_tlast on the fifth.
// s_tready is low while rounds, folding, padding or digest output are under way;
// the last digest word may still wait in the output register while the next
// message starts. After the digest the block is back at its initial state.
module sha1_stream_hasher_top
    import sha1_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] data_byte
    input  wire  [0:0]  s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        m_tlast    // last_word
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_FOLD  = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t      state_reg;
    logic [5:0]  fill_reg;
    logic [54:0] blocks_reg;
    logic [63:0] len_reg;
    logic        mark_reg;
    logic        len_ok_reg;
    logic        final_reg;
    logic        pad_reg;
    rnd_idx_t    rnd_reg;
    logic [2:0]  idx_reg;
    logic        m_tvalid_reg;
    word_t       m_word_reg;
    logic [2:0]  m_idx_reg;
    logic        m_last_reg;

    logic        in_acc;
    logic        out_load;
    logic        len_byte;
    logic [7:0]  pad_byte;
    sched_ctrl_t sched_ctrl;
    rnd_ctrl_t   rnd_ctrl;
    word_t       w_cur;
    chain_t      chain;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, m_idx_reg, m_word_reg};
    assign m_tlast  = m_last_reg;

    // Pick the padding byte: marker, length or zero
    always_comb begin
        len_byte = !mark_reg && len_ok_reg && (fill_reg >= LEN_POS);
        if (mark_reg) begin
            pad_byte = PAD_MARK;
        end else if (len_byte) begin
            pad_byte = len_reg[63:56];
        end else begin
            pad_byte = 8'h00;
        end
    end

    // Drive the window and the round unit
    always_comb begin
        sched_ctrl.push_byte = (in_acc && (s_tuser[0] == CMD_ABSORB)) || (state_reg == ST_PAD);
        sched_ctrl.byte_val  = (state_reg == ST_PAD) ? pad_byte : s_tdata;
        sched_ctrl.step      = (state_reg == ST_ROUND);

        rnd_ctrl.load = sched_ctrl.push_byte && (fill_reg == FILL_LAST);
        rnd_ctrl.step = (state_reg == ST_ROUND);
        rnd_ctrl.fold = (state_reg == ST_FOLD);
        rnd_ctrl.init = out_load && (idx_reg == WORD_LAST);
        rnd_ctrl.rnd  = rnd_reg;
    end

    sha1_sched u_sched (
        .aclk  (aclk),
        .ctrl  (sched_ctrl),
        .w_cur (w_cur)
    );

    sha1_round u_round (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (rnd_ctrl),
        .w_cur   (w_cur),
        .chain   (chain)
    );

    // Sequencer: absorb, pad, run rounds, fold, emit digest
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fill_reg     <= 6'd0;
            blocks_reg   <= 55'd0;
            mark_reg     <= 1'b0;
            len_ok_reg   <= 1'b0;
            final_reg    <= 1'b0;
            pad_reg      <= 1'b0;
            rnd_reg      <= 7'd0;
            idx_reg      <= 3'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (s_tuser[0] == CMD_ABSORB) begin
                            fill_reg <= fill_reg + 6'd1;
                            pad_reg  <= 1'b0;
                            if (fill_reg == FILL_LAST) begin
                                blocks_reg <= blocks_reg + 55'd1;
                                rnd_reg    <= 7'd0;
                                state_reg  <= ST_ROUND;
                            end
                        end else begin
                            mark_reg   <= 1'b1;
                            len_ok_reg <= (fill_reg < LEN_POS);
                            final_reg  <= 1'b0;
                            pad_reg    <= 1'b1;
                            state_reg  <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    mark_reg <= 1'b0;
                    fill_reg <= fill_reg + 6'd1;
                    if (fill_reg == FILL_LAST) begin
                        final_reg  <= len_ok_reg;
                        len_ok_reg <= 1'b1;
                        rnd_reg    <= 7'd0;
                        state_reg  <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    rnd_reg <= rnd_reg + 7'd1;
                    if (rnd_reg == RND_LAST) begin
                        state_reg <= ST_FOLD;
                    end
                end
                ST_FOLD: begin
                    if (!pad_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (final_reg) begin
                        idx_reg   <= 3'd0;
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_PAD;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        if (idx_reg == WORD_LAST) begin
                            idx_reg    <= 3'd0;
                            blocks_reg <= 55'd0;
                            fill_reg   <= 6'd0;
                            pad_reg    <= 1'b0;
                            state_reg  <= ST_IDLE;
                        end else begin
                            idx_reg <= idx_reg + 3'd1;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Capture the bit length at finish, then shift it out a byte at a time
    always_ff @(posedge aclk) begin
        if (in_acc && (s_tuser[0] == CMD_FINISH)) begin
            len_reg <= {blocks_reg, fill_reg, 3'b000};
        end else if ((state_reg == ST_PAD) && len_byte) begin
            len_reg <= {len_reg[55:0], 8'h00};
        end
    end

    // Hold the outgoing digest word
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_word_reg <= chain[idx_reg];
            m_idx_reg  <= idx_reg;
            m_last_reg <= (idx_reg == WORD_LAST);
        end
    end

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for the SHA-1 stream hasher: random messages, digest scoreboard.
`timescale 1ns / 100ps

module testbench;
    import sha1_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic [0:0]  s_tuser;   // [0] cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [31:0] digest_word, [34:32] word_index
    logic        m_tlast;   // last_word

    int unsigned words_sent;
    int unsigned messages_sent;

    // One digest word as it should leave the block
    typedef struct {
        word_t      word;
        logic [2:0] index;
        logic       last;
    } digest_word_t;

    // Bit-accurate SHA-1 model plus the queue of digest words still to arrive
    class sha1_scoreboard;
        word_t          chain[5];
        logic [7:0]     msg_block[64];
        logic [5:0]     fill;
        logic [63:0]    msg_bits;
        digest_word_t   digest_q[$];
        int unsigned    errors;

        function new();
            errors = 0;
            foreach (msg_block[i]) msg_block[i] = 8'h00;
            restart_message();
        endfunction

        function void restart_message();
            for (int j = 0; j < 5; j++) chain[j] = CHAIN_IV[j];
            fill     = '0;
            msg_bits = '0;
        endfunction

        // Run the 80 rounds over msg_block and fold into the chaining words
        function void compress_block();
            word_t w[80];
            word_t a, b, c, d, e, f, k, t, x;
            for (int i = 0; i < 16; i++) begin
                w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
            end
            for (int i = 16; i < 80; i++) begin
                x    = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
                w[i] = {x[30:0], x[31]};
            end
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            e = chain[4];
            for (int i = 0; i < 80; i++) begin
                if (i < 20) begin
                    f = (b & c) | (~b & d);
                    k = K_CH;
                end else if (i < 40) begin
                    f = b ^ c ^ d;
                    k = K_PAR;
                end else if (i < 60) begin
                    f = (b & c) | (b & d) | (c & d);
                    k = K_MAJ;
                end else begin
                    f = b ^ c ^ d;
                    k = K_XOR;
                end
                t = {a[26:0], a[31:27]} + f + e + k + w[i];
                e = d;
                d = c;
                c = {b[1:0], b[31:2]};
                b = a;
                a = t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
            chain[4] += e;
        endfunction

        // Absorb a byte, or pad the message and queue its five digest words
        function void note_input(logic cmd, logic [7:0] data_byte);
            logic [63:0]  total;
            int           pos;
            digest_word_t dw;
            if (cmd == CMD_ABSORB) begin
                msg_block[fill] = data_byte;
                if (fill == FILL_LAST) begin
                    compress_block();
                    msg_bits += 64'd512;
                    fill = '0;
                end else begin
                    fill = fill + 6'd1;
                end
                return;
            end
            total = msg_bits + 64'(fill) * 64'd8;
            pos   = fill;
            msg_block[pos] = PAD_MARK;
            pos++;
            // No room for the length: close this block and use a second one
            if (pos > LEN_POS) begin
                while (pos < 64) begin
                    msg_block[pos] = 8'h00;
                    pos++;
                end
                compress_block();
                pos = 0;
            end
            while (pos < LEN_POS) begin
                msg_block[pos] = 8'h00;
                pos++;
            end
            for (int i = 0; i < 8; i++) msg_block[LEN_POS + i] = total[63 - 8*i -: 8];
            compress_block();
            for (int i = 0; i < 5; i++) begin
                dw.word  = chain[i];
                dw.index = 3'(i);
                dw.last  = (3'(i) == WORD_LAST);
                digest_q.push_back(dw);
            end
            restart_message();
        endfunction

        // Compare one accepted output word against the oldest expected word
        function void check_result(logic [39:0] data, logic last);
            digest_word_t dw;
            if (digest_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected digest word %h index %0d last %b",
                             $realtime, data[31:0], data[34:32], last);
                return;
            end
            dw = digest_q.pop_front();
            if (data[31:0] !== dw.word || data[34:32] !== dw.index || last !== dw.last) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                             $realtime, dw.word, dw.index, dw.last,
                             data[31:0], data[34:32], last);
            end
        endfunction

        function int pending();
            return digest_q.size();
        endfunction
    endclass

    sha1_scoreboard digest_sb = new();

    sha1_stream_hasher_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    // Idle cycles before the next word; zero throughout a burst
    function automatic int draw_gap(bit burst);
        return burst ? 0 : int'($urandom_range(0, 12));
    endfunction

    // Present one word after an idle gap and hold it until accepted
    task automatic send_word(int gap, logic cmd, logic [7:0] data_byte);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom_range(0, 255));
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data_byte;
        s_tuser  <= cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        digest_sb.note_input(cmd, data_byte);
        words_sent++;
    endtask

    // Random bytes followed by a finish word with a junk data byte
    task automatic send_message(int len, bit burst);
        for (int i = 0; i < len; i++)
            send_word(draw_gap(burst), CMD_ABSORB, 8'($urandom_range(0, 255)));
        send_word(draw_gap(burst), CMD_FINISH, 8'($urandom_range(0, 255)));
        messages_sent++;
    endtask

    // Accept digest words with random back-pressure, sometimes none for a while
    initial begin
        int  stall;
        bit  rx_burst;
        rx_burst = 1'b0;
        m_tready <= 1'b0;
        wait (aresetn == 1'b1);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 7) == 0) rx_burst = !rx_burst;
            stall = rx_burst ? 0 : int'($urandom_range(0, 12));
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            digest_sb.check_result(m_tdata, m_tlast);
        end
    end

    // Reset, directed messages, random messages, drain
    initial begin
        int len;
        words_sent    = 0;
        messages_sent = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tuser  <= CMD_ABSORB;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty message, finish carrying an all-ones byte that must be ignored
        send_word(0, CMD_FINISH, 8'hFF);
        // "abc" back to back
        send_word(0, CMD_ABSORB, 8'h61);
        send_word(0, CMD_ABSORB, 8'h62);
        send_word(0, CMD_ABSORB, 8'h63);
        send_word(0, CMD_FINISH, 8'h00);
        // Extreme byte values with gaps
        send_word(3, CMD_ABSORB, 8'h00);
        send_word(5, CMD_ABSORB, 8'hFF);
        send_word(1, CMD_ABSORB, 8'h80);
        send_word(7, CMD_ABSORB, 8'h7F);
        send_word(2, CMD_FINISH, 8'hA5);
        // Finish straight after a finish: a second empty message
        send_word(0, CMD_FINISH, 8'h00);

        // Length field needs a second padding block, then an exact full block
        send_message(56, 1'b0);
        send_message(64, ($urandom_range(0, 1) == 0));

        // Mostly short messages, some near the block boundary
        while (words_sent < 100) begin
            if ($urandom_range(0, 9) < 7) len = $urandom_range(0, 9);
            else len = $urandom_range(50, 70);
            send_message(len, ($urandom_range(0, 3) == 0));
        end
        s_tvalid <= 1'b0;

        // Drain, then give the block time to show any stray word
        while (digest_sb.pending() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (digest_sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
